// File: sv/lpht_pkg.sv
// Shared widths, codes, state encoding and control structs of the hash table.
`default_nettype none

package lpht_pkg;

   localparam int OP_W      = 2;
   localparam int KEY_W     = 31;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 3;
   localparam int MARK_W    = 2;

   // Key reduction modulo the table depth runs one hex digit per cycle.
   localparam int DIGIT_W   = 4;
   localparam int KEY_PAD_W = 32;
   localparam int MOD_STEPS = KEY_PAD_W / DIGIT_W;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

   localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] STS_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STS_DELETED  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd5;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_ISSUE,
      S_PROBE,
      S_DONE
   } fsm_state_type;

   typedef struct packed {
      logic req_ready;
      logic accept;
      logic mod_step;
      logic read_home;
      logic probe;
      logic commit;
      logic clear;
   } lpht_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic op_ok;
      logic mod_done;
      logic probe_stop;
      logic clear_done;
      logic rsp_free;
   } lpht_stat_type;

endpackage

`default_nettype wire

// File: sv/lpht_if.sv
// Request and response channel interfaces of the hash table.
`default_nettype none

interface lpht_req_if import lpht_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [KEY_W-1:0]     key;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, output op, output key, output payload, input ready);
   modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [PAYLOAD_W-1:0] data_out;

   modport source (output valid, output status, output data_out, input ready);
   modport sink   (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

// File: sv/linear_probe_hash_table.sv
// Top level of the linear-probing hash table: controller and datapath.
//
//   Channel    Direction  Contents
//   req_chan   in         op, key, payload
//   rsp_chan   out        status, data_out
//
// An accepted item passes through key reduction, a read of the home slot, a probe of P
// slots (1 to TABLE_DEPTH), one per cycle through the registered memory read, and a commit.
// For a depth that is not a power of two, the key reduction steps through the key by digits.
// An unused op code skips the key reduction and the probe and goes straight to its result.
// After reset, a clearing pass over every slot empties the slot marks; no item
// is accepted meanwhile. A waiting result sits in an output register, so the next item
// is accepted while it waits; a new result waits only if the old one is still there.
`default_nettype none

module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   lpht_req_if.sink   req_chan,
   lpht_rsp_if.source rsp_chan
);

   lpht_cmd_type  cmd;
   lpht_stat_type stat;

   lpht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   lpht_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

`default_nettype wire

// File: sv/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sv/lpht_ctrl.sv
// Controller state machine that sequences clearing, key reduction, probing and commit.
`default_nettype none

module lpht_ctrl import lpht_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lpht_stat_type stat,
   output lpht_cmd_type       cmd
);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (stat.req_valid) state_in = stat.op_ok ? S_HOME : S_DONE;
         end
         S_HOME: begin
            if (stat.mod_done) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (stat.probe_stop) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.accept    = stat.req_valid;
         end
         S_HOME: begin
            cmd.mod_step = 1'b1;
         end
         S_ISSUE: begin
            cmd.read_home = 1'b1;
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
         end
         S_DONE: begin
            cmd.commit = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/lpht_datapath.sv
// Datapath with slot memories, key reduction, probe evaluation and the result register.
`default_nettype none

module lpht_datapath import lpht_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   lpht_req_if.sink          req_chan,
   lpht_rsp_if.source        rsp_chan,
   input  wire lpht_cmd_type cmd,
   output lpht_stat_type     stat
);

   localparam int              IDX_W     = $clog2(TABLE_DEPTH);
   localparam bit              IS_POW2   = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W:0]  DEPTH_EXT = (IDX_W + 1)'(TABLE_DEPTH);
   localparam int              ENTRY_W   = KEY_W + PAYLOAD_W;

   // Shifts one digit of the key into the running remainder.
   function automatic logic [IDX_W-1:0] mod_digit(input logic [IDX_W-1:0] rem,
                                                  input logic [DIGIT_W-1:0] digit);
      logic [IDX_W:0] r;
      r = {1'b0, rem};
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         r = {r[IDX_W-1:0], digit[i]};
         if (r >= DEPTH_EXT) r = r - DEPTH_EXT;
      end
      return r[IDX_W-1:0];
   endfunction

   logic [OP_W-1:0]      op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [KEY_PAD_W-1:0] kshift_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [IDX_W-1:0]     rem_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     count_ff;
   logic                 tomb_valid_ff;
   logic [IDX_W-1:0]     tomb_idx_ff;
   logic                 wr_mark_en_ff;
   logic                 wr_entry_en_ff;
   logic [IDX_W-1:0]     wr_idx_ff;
   logic [MARK_W-1:0]    wr_mark_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic [PAYLOAD_W-1:0] res_data_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [PAYLOAD_W-1:0] rsp_data_ff;
   logic [IDX_W-1:0]     clr_idx_ff;

   logic [MARK_W-1:0]    mark_rd;
   logic [ENTRY_W-1:0]   entry_rd;
   logic [KEY_W-1:0]     rd_key;
   logic [PAYLOAD_W-1:0] rd_payload;
   logic                 is_empty;
   logic                 is_used;
   logic                 is_hit;
   logic                 is_tomb;
   logic                 is_last;
   logic                 probe_stop;
   logic                 tomb_any;
   logic [IDX_W-1:0]     tomb_sel;
   logic [IDX_W-1:0]     next_idx;
   logic [IDX_W-1:0]     raddr;

   logic                 dec_mark_en;
   logic                 dec_entry_en;
   logic [IDX_W-1:0]     dec_idx;
   logic [MARK_W-1:0]    dec_mark;
   logic [STATUS_W-1:0]  dec_status;
   logic [PAYLOAD_W-1:0] dec_data;

   logic                 mark_we;
   logic [IDX_W-1:0]     mark_waddr;
   logic [MARK_W-1:0]    mark_wdata;
   logic                 entry_we;

   assign rd_key     = entry_rd[PAYLOAD_W +: KEY_W];
   assign rd_payload = entry_rd[PAYLOAD_W-1:0];
   assign is_empty   = mark_rd == MARK_EMPTY;
   assign is_used    = mark_rd == MARK_USED;
   assign is_hit     = is_used && (rd_key == key_ff);
   assign is_tomb    = !is_empty && !is_used;
   assign is_last    = count_ff == LAST_IDX;
   assign probe_stop = is_hit || is_empty || is_last;
   assign tomb_any   = tomb_valid_ff || is_tomb;
   assign tomb_sel   = tomb_valid_ff ? tomb_idx_ff : idx_ff;
   assign next_idx   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign raddr      = cmd.read_home ? rem_ff : next_idx;

   always_comb begin
      dec_mark_en  = 1'b0;
      dec_entry_en = 1'b0;
      dec_idx      = idx_ff;
      dec_mark     = MARK_USED;
      dec_status   = STS_NOTFOUND;
      dec_data     = '0;
      case (op_ff)
         OP_INSERT: begin
            if (is_hit) begin
               dec_entry_en = 1'b1;
               dec_status   = STS_UPDATED;
            end else if (tomb_any) begin
               dec_mark_en  = 1'b1;
               dec_entry_en = 1'b1;
               dec_idx      = tomb_sel;
               dec_status   = STS_INSERTED;
            end else if (is_empty) begin
               dec_mark_en  = 1'b1;
               dec_entry_en = 1'b1;
               dec_status   = STS_INSERTED;
            end else begin
               dec_status = STS_FULL;
            end
         end
         OP_DELETE: begin
            if (is_hit) begin
               dec_mark_en = 1'b1;
               dec_mark    = MARK_TOMB;
               dec_status  = STS_DELETED;
            end
         end
         OP_LOOKUP: begin
            if (is_hit) begin
               dec_status = STS_FOUND;
               dec_data   = rd_payload;
            end
         end
         default: begin
            dec_status = STS_NOTFOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff          <= req_chan.op;
         key_ff         <= req_chan.key;
         payload_ff     <= req_chan.payload;
         kshift_ff      <= KEY_PAD_W'(req_chan.key);
         step_ff        <= '0;
         rem_ff         <= IS_POW2 ? req_chan.key[IDX_W-1:0] : '0;
         tomb_valid_ff  <= 1'b0;
         wr_mark_en_ff  <= 1'b0;
         wr_entry_en_ff <= 1'b0;
         res_status_ff  <= STS_NOTFOUND;
         res_data_ff    <= '0;
      end
      if (cmd.mod_step && !IS_POW2) begin
         rem_ff    <= mod_digit(rem_ff, kshift_ff[KEY_PAD_W-1 -: DIGIT_W]);
         kshift_ff <= kshift_ff << DIGIT_W;
         step_ff   <= step_ff + 1'b1;
      end
      if (cmd.read_home) begin
         idx_ff   <= rem_ff;
         count_ff <= '0;
      end
      if (cmd.probe) begin
         if (probe_stop) begin
            wr_mark_en_ff  <= dec_mark_en;
            wr_entry_en_ff <= dec_entry_en;
            wr_idx_ff      <= dec_idx;
            wr_mark_ff     <= dec_mark;
            res_status_ff  <= dec_status;
            res_data_ff    <= dec_data;
         end else begin
            idx_ff   <= next_idx;
            count_ff <= count_ff + 1'b1;
            if (is_tomb && !tomb_valid_ff) begin
               tomb_valid_ff <= 1'b1;
               tomb_idx_ff   <= idx_ff;
            end
         end
      end
      if (cmd.commit) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_idx_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear && (clr_idx_ff != LAST_IDX)) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   assign mark_we    = cmd.clear || (cmd.commit && wr_mark_en_ff);
   assign mark_waddr = cmd.clear ? clr_idx_ff : wr_idx_ff;
   assign mark_wdata = cmd.clear ? MARK_EMPTY : wr_mark_ff;
   assign entry_we   = cmd.commit && wr_entry_en_ff;

   lpht_ram #(
      .WIDTH (MARK_W),
      .DEPTH (TABLE_DEPTH)
   ) u_mark_ram (
      .clock (clock),
      .we    (mark_we),
      .waddr (mark_waddr),
      .wdata (mark_wdata),
      .raddr (raddr),
      .rdata (mark_rd)
   );

   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (entry_we),
      .waddr (wr_idx_ff),
      .wdata ({key_ff, payload_ff}),
      .raddr (raddr),
      .rdata (entry_rd)
   );

   assign req_chan.ready    = cmd.req_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.data_out = rsp_data_ff;

   assign stat.req_valid  = req_chan.valid;
   assign stat.op_ok      = req_chan.op <= OP_LOOKUP;
   assign stat.mod_done   = IS_POW2 || (step_ff == STEP_W'(MOD_STEPS - 1));
   assign stat.probe_stop = probe_stop;
   assign stat.clear_done = clr_idx_ff == LAST_IDX;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   a_data_only_on_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STS_FOUND)) |-> (rsp_data_ff == '0))
      else $error("Response data is nonzero on a result other than found.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("A result was loaded over one not yet taken.");

   a_home_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.read_home |-> ({1'b0, rem_ff} < DEPTH_EXT))
      else $error("The home slot lies outside the table.");

   a_mark_write_code: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && wr_mark_en_ff) |-> ((wr_mark_ff == MARK_USED) || (wr_mark_ff == MARK_TOMB)))
      else $error("A commit writes an empty mark.");

endmodule

`default_nettype wire
